### hw/rtl/mlss_pkg.sv
// Shared types, codes and constants of the multichannel LED strip serializer.
package mlss_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int MAX_LEDS_DEF = 1024;

    localparam int WORD_W     = 32;
    localparam int COUNT_W    = 11;
    localparam int CNT_W      = 20;
    localparam int HIGH_W     = 12;
    localparam int LINE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int MIN_LEDS   = 3;

    localparam logic [4:0] TOP_BIT_24 = 5'd23;
    localparam logic [4:0] TOP_BIT_32 = 5'd31;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_SHOW  = 2'd1,
        OP_TICK  = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SHIFT = 2'd1,
        PH_GAP   = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_LOAD,
        ST_RESP
    } t_state;

    typedef enum logic [2:0] {
        CFG_CHANNEL_MASK = 3'd0,
        CFG_LED_COUNT    = 3'd1,
        CFG_PIXEL_TYPE   = 3'd2,
        CFG_BRIGHTNESS   = 3'd3,
        CFG_ZERO_HIGH    = 3'd4,
        CFG_ONE_HIGH     = 3'd5,
        CFG_BIT_PERIOD   = 3'd6,
        CFG_RESET_GAP    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0] opcode;
        logic [4:0] channel;
        logic [9:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] white;
    } t_cmd;

    typedef struct packed {
        logic [7:0] line_levels;
        logic [1:0] status;
        logic       rejected;
    } t_result;

    typedef struct packed {
        logic [HIGH_W-1:0] zero_high;
        logic [HIGH_W-1:0] one_high;
    } t_bit_timing;

endpackage

### hw/rtl/multichannel_led_strip_serializer.sv
// Top level of the multichannel LED strip serializer: sequencer, registers, frame store.
//
// Frame buffer and single-wire waveform generator for up to eight LED strips. Issue a
// command with start while busy is low; the command is a pixel write, a show, or one
// tick of the line waveform. Every command yields exactly one result on o_result,
// flagged by o_done for a single cycle; there is no way to hold it, so capture it
// when o_done is high. A write, a show that is refused or that goes straight to the
// reset gap, a tick that loads no new words, and an unused opcode pass from acceptance
// through the execute and response states to o_done; a show or tick that loads the
// next LED's words also passes through the load state, for the frame store's
// registered read. busy is low again in the o_done cycle, so the next command may be
// issued there. After reset the store is cleared one row per cycle, with busy high;
// configuration writes are taken at all times (o_cfg_ready is always high) and
// should be issued only while no command is in progress.
module multichannel_led_strip_serializer #(
    parameter int CHANNELS = mlss_pkg::CHANNELS_DEF,
    parameter int MAX_LEDS = mlss_pkg::MAX_LEDS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  mlss_pkg::t_cmd                  i_cmd,
    output logic                            o_done,
    output mlss_pkg::t_result               o_result,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mlss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mlss_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mlss_pkg::*;

    // Only channels 0..7 can be enabled or reported, so only those get storage.
    localparam int LANES = (CHANNELS < LINE_W) ? CHANNELS : LINE_W;
    localparam int AW    = $clog2(MAX_LEDS);
    localparam logic [AW-1:0] LAST_ROW = AW'(MAX_LEDS - 1);

    // Configuration registers
    logic [7:0]         r_channel_mask;
    logic [COUNT_W-1:0] r_led_count;
    logic [7:0]         r_pixel_type;
    logic [7:0]         r_brightness;
    logic [HIGH_W-1:0]  r_zero_high;
    logic [HIGH_W-1:0]  r_one_high;
    logic [HIGH_W-1:0]  r_bit_period;
    logic [CNT_W-1:0]   r_reset_gap;

    // Sequencer and waveform state
    t_state             r_state, n_state;
    t_phase             r_phase, n_phase;
    logic [AW-1:0]      r_clr, n_clr;
    logic [COUNT_W-1:0] r_led_pos, n_led_pos;
    logic [4:0]         r_bit_pos, n_bit_pos;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_rej, n_rej;
    logic               r_out_valid, n_out_valid;
    t_result            r_result, n_result;
    t_cmd               r_item;
    logic [LANES-1:0][WORD_W-1:0] r_shift, n_shift;

    // Frame store port signals
    logic [LANES-1:0]             mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [WORD_W-1:0]            mem_wdata;
    logic                         mem_re;
    logic [AW-1:0]                mem_raddr;
    logic [LANES-1:0][WORD_W-1:0] mem_rdata;

    logic [COUNT_W-1:0] eff_count;
    logic [LANES-1:0]   lane_en;
    logic [LANES-1:0]   lane_sel;
    logic               wr_ok;
    logic [4:0]         top_bit;
    logic [WORD_W-1:0]  pack_word;
    logic [LINE_W-1:0]  line_lv;
    logic [CNT_W-1:0]   cnt_inc;
    logic [COUNT_W-1:0] pos_inc;
    logic [4:0]         bit_dec;
    logic [CNT_W-1:0]   period;
    logic [CNT_W-1:0]   gap;
    t_bit_timing        timing;

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_state != ST_IDLE);
    assign o_done      = r_out_valid;
    assign o_result    = r_result;

    // Configuration writes: take a transfer whenever valid is high.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_mask <= '0;
            r_led_count    <= '0;
            r_pixel_type   <= '0;
            r_brightness   <= '0;
            r_zero_high    <= HIGH_W'(22);
            r_one_high     <= HIGH_W'(75);
            r_bit_period   <= HIGH_W'(97);
            r_reset_gap    <= CNT_W'(30000);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CHANNEL_MASK: r_channel_mask <= i_cfg_data[7:0];
                CFG_LED_COUNT:    r_led_count    <= i_cfg_data[COUNT_W-1:0];
                CFG_PIXEL_TYPE:   r_pixel_type   <= i_cfg_data[7:0];
                CFG_BRIGHTNESS:   r_brightness   <= i_cfg_data[7:0];
                CFG_ZERO_HIGH:    r_zero_high    <= i_cfg_data[HIGH_W-1:0];
                CFG_ONE_HIGH:     r_one_high     <= i_cfg_data[HIGH_W-1:0];
                CFG_BIT_PERIOD:   r_bit_period   <= i_cfg_data[HIGH_W-1:0];
                CFG_RESET_GAP:    r_reset_gap    <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective LED count: zero stays zero, one and two become three, clamp to depth.
    always_comb begin
        if (r_led_count == '0) begin
            eff_count = '0;
        end else if (r_led_count < COUNT_W'(MIN_LEDS)) begin
            eff_count = COUNT_W'(MIN_LEDS);
        end else if (32'(r_led_count) > MAX_LEDS) begin
            eff_count = COUNT_W'(MAX_LEDS);
        end else begin
            eff_count = r_led_count;
        end
    end

    assign lane_en = (eff_count != '0) ? r_channel_mask[LANES-1:0] : '0;

    // Decode the write channel into a lane; an out-of-range channel selects nothing.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            lane_sel[l] = (r_item.channel == 5'(l));
        end
    end

    assign wr_ok   = ((lane_sel & lane_en) != '0)
                  && ({1'b0, r_item.led_index} < eff_count);
    assign top_bit = (r_pixel_type[7:6] == r_pixel_type[5:4]) ? TOP_BIT_24 : TOP_BIT_32;

    assign cnt_inc = r_cnt + CNT_W'(1);
    assign pos_inc = r_led_pos + COUNT_W'(1);
    assign bit_dec = r_bit_pos - 5'd1;
    // A zero period or gap is taken as a value of one.
    assign period  = (r_bit_period == '0) ? CNT_W'(1) : CNT_W'(r_bit_period);
    assign gap     = (r_reset_gap == '0) ? CNT_W'(1) : r_reset_gap;

    assign timing.zero_high = r_zero_high;
    assign timing.one_high  = r_one_high;

    mlss_pack u_pack (
        .i_cmd        (r_item),
        .i_pixel_type (r_pixel_type),
        .i_brightness (r_brightness),
        .o_word       (pack_word)
    );

    mlss_store #(
        .LANES (LANES),
        .DEPTH (MAX_LEDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    mlss_line #(
        .LANES (LANES)
    ) u_line (
        .i_shift    (r_shift),
        .i_bit_pos  (r_bit_pos),
        .i_cnt      (r_cnt),
        .i_timing   (timing),
        .i_lane_en  (lane_en),
        .i_shifting (r_phase == PH_SHIFT),
        .o_levels   (line_lv)
    );

    // Sequencer: next state, waveform update and frame store requests.
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_clr       = r_clr;
        n_led_pos   = r_led_pos;
        n_bit_pos   = r_bit_pos;
        n_cnt       = r_cnt;
        n_rej       = r_rej;
        n_out_valid = 1'b0;
        n_result    = r_result;
        n_shift     = r_shift;
        mem_we      = '0;
        mem_waddr   = AW'(r_item.led_index);
        mem_wdata   = pack_word;
        mem_re      = 1'b0;
        mem_raddr   = AW'(pos_inc);

        case (r_state)
            ST_CLEAR: begin
                // Zero one row per cycle so every LED starts off.
                mem_we    = '1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                if (r_clr == LAST_ROW) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end

            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end

            ST_EXEC: begin
                n_rej   = 1'b0;
                n_state = ST_RESP;
                case (r_item.opcode)
                    OP_WRITE: begin
                        if (wr_ok) begin
                            mem_we = lane_sel;
                        end else begin
                            n_rej = 1'b1;
                        end
                    end

                    OP_SHOW: begin
                        if (r_phase != PH_IDLE) begin
                            n_rej = 1'b1;
                        end else begin
                            n_led_pos = '0;
                            n_cnt     = '0;
                            if (eff_count == '0) begin
                                // Nothing to send: go straight to the reset gap.
                                n_phase   = PH_GAP;
                                n_bit_pos = '0;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = '0;
                                n_bit_pos = top_bit;
                                n_phase   = PH_SHIFT;
                                n_state   = ST_LOAD;
                            end
                        end
                    end

                    OP_TICK: begin
                        if (r_phase == PH_SHIFT) begin
                            if (cnt_inc >= period) begin
                                n_cnt = '0;
                                if (r_bit_pos == '0) begin
                                    // LED boundary: advance, then fetch the next row or enter the reset gap.
                                    n_led_pos = pos_inc;
                                    if (pos_inc >= eff_count) begin
                                        n_phase = PH_GAP;
                                    end else begin
                                        mem_re    = 1'b1;
                                        n_bit_pos = top_bit;
                                        n_state   = ST_LOAD;
                                    end
                                end else if (bit_dec > top_bit) begin
                                    // Pixel size shrank mid-LED: drop to the new top bit.
                                    n_bit_pos = top_bit;
                                end else begin
                                    n_bit_pos = bit_dec;
                                end
                            end else begin
                                n_cnt = cnt_inc;
                            end
                        end else if (r_phase == PH_GAP) begin
                            if (cnt_inc >= gap) begin
                                n_cnt     = '0;
                                n_led_pos = '0;
                                n_bit_pos = '0;
                                n_phase   = PH_IDLE;
                            end else begin
                                n_cnt = cnt_inc;
                            end
                        end
                    end

                    default: ;
                endcase
            end

            ST_LOAD: begin
                // Registered read data is here: load every channel's word.
                n_shift = mem_rdata;
                n_state = ST_RESP;
            end

            ST_RESP: begin
                n_result.line_levels = line_lv;
                n_result.status      = r_phase;
                n_result.rejected    = r_rej;
                n_out_valid          = 1'b1;
                n_state              = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_phase     <= PH_IDLE;
            r_clr       <= '0;
            r_led_pos   <= '0;
            r_bit_pos   <= '0;
            r_cnt       <= '0;
            r_rej       <= 1'b0;
            r_out_valid <= 1'b0;
            r_shift     <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_clr       <= n_clr;
            r_led_pos   <= n_led_pos;
            r_bit_pos   <= n_bit_pos;
            r_cnt       <= n_cnt;
            r_rej       <= n_rej;
            r_out_valid <= n_out_valid;
            r_shift     <= n_shift;
        end
    end

    // Payload: hold the accepted command and the pending result.
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_item <= i_cmd;
        end
        r_result <= n_result;
    end

    a_done_after_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == ST_RESP))
        else $error("result strobe without a response cycle");

    a_load_while_shifting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> (r_phase == PH_SHIFT))
        else $error("shift word load outside the shifting phase");

    a_lines_low_off_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_SHIFT) |-> (line_lv == '0))
        else $error("data line high outside the shifting phase");

    a_clear_blocks_cmds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |=> ((r_state == ST_CLEAR) || (r_state == ST_IDLE)))
        else $error("command started during the frame store clear");

endmodule

### hw/rtl/mlss_store.sv
// Frame store: one row per LED position, one 32-bit lane per channel.
module mlss_store #(
    parameter int LANES = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                                  i_clk,
    input  logic [LANES-1:0]                      i_we,
    input  logic [AW-1:0]                         i_waddr,
    input  logic [mlss_pkg::WORD_W-1:0]           i_wdata,
    input  logic                                  i_re,
    input  logic [AW-1:0]                         i_raddr,
    output logic [LANES-1:0][mlss_pkg::WORD_W-1:0] o_rdata
);
    import mlss_pkg::*;

    logic [LANES-1:0][WORD_W-1:0] mem [DEPTH];
    logic [LANES-1:0][WORD_W-1:0] r_rdata;

    // Lane-enabled write, one row address per cycle.
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            if (i_we[l]) begin
                mem[i_waddr][l] <= i_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/mlss_pack.sv
// Brightness scaling and byte packing of one pixel word.
module mlss_pack (
    input  mlss_pkg::t_cmd                i_cmd,
    input  logic [7:0]                    i_pixel_type,
    input  logic [7:0]                    i_brightness,
    output logic [mlss_pkg::WORD_W-1:0]   o_word
);
    import mlss_pkg::*;

    function automatic logic [7:0] scale_byte(input logic [7:0] c, input logic [7:0] b);
        logic [15:0] prod;
        prod = 16'(c) * 16'(b);
        return (b != 8'd0) ? prod[15:8] : c;
    endfunction

    logic [7:0] s_red, s_green, s_blue, s_white;
    logic       wide;

    assign s_red   = scale_byte(i_cmd.red,   i_brightness);
    assign s_green = scale_byte(i_cmd.green, i_brightness);
    assign s_blue  = scale_byte(i_cmd.blue,  i_brightness);
    assign s_white = scale_byte(i_cmd.white, i_brightness);

    // White sharing the red position marks a 24-bit pixel.
    assign wide = (i_pixel_type[7:6] != i_pixel_type[5:4]);

    always_comb begin
        o_word = (WORD_W'(s_red)   << {i_pixel_type[5:4], 3'b000})
               | (WORD_W'(s_green) << {i_pixel_type[3:2], 3'b000})
               | (WORD_W'(s_blue)  << {i_pixel_type[1:0], 3'b000});
        if (wide) begin
            o_word = o_word | (WORD_W'(s_white) << {i_pixel_type[7:6], 3'b000});
        end
    end

endmodule

### hw/rtl/mlss_line.sv
// Data line levels from the shift words and the bit timing.
module mlss_line #(
    parameter int LANES = 8
) (
    input  logic [LANES-1:0][mlss_pkg::WORD_W-1:0] i_shift,
    input  logic [4:0]                             i_bit_pos,
    input  logic [mlss_pkg::CNT_W-1:0]             i_cnt,
    input  mlss_pkg::t_bit_timing                  i_timing,
    input  logic [LANES-1:0]                       i_lane_en,
    input  logic                                   i_shifting,
    output logic [mlss_pkg::LINE_W-1:0]            o_levels
);
    import mlss_pkg::*;

    always_comb begin
        o_levels = '0;
        for (int c = 0; c < LANES; c++) begin
            if (i_shifting && i_lane_en[c]) begin
                if (i_shift[c][i_bit_pos]) begin
                    o_levels[c] = (i_cnt < CNT_W'(i_timing.one_high));
                end else begin
                    o_levels[c] = (i_cnt < CNT_W'(i_timing.zero_high));
                end
            end
        end
    end

endmodule

### verif/mlss_checker.sv
// Checker for the LED strip serializer: predicts every result and compares it on arrival.
module mlss_checker #(
    parameter int CHANNELS = mlss_pkg::CHANNELS_DEF,
    parameter int MAX_LEDS = mlss_pkg::MAX_LEDS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  mlss_pkg::t_cmd                  i_cmd,
    input  logic                            i_done,
    input  mlss_pkg::t_result               i_result,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [mlss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mlss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_mismatches,
    output int                              o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import mlss_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // register copies
    logic [7:0]         chan_mask;
    logic [COUNT_W-1:0] strip_len;
    logic [7:0]         pix_layout;
    logic [7:0]         bright;
    logic [HIGH_W-1:0]  zero_high;
    logic [HIGH_W-1:0]  one_high;
    logic [HIGH_W-1:0]  bit_period;
    logic [CNT_W-1:0]   gap_len;

    // waveform state
    logic [WORD_W-1:0]  frame_mem [CHANNELS*MAX_LEDS];
    logic [WORD_W-1:0]  out_word [CHANNELS];
    logic [COUNT_W-1:0] led_pos;
    logic [4:0]         bit_pos;
    logic [CNT_W-1:0]   cyc;
    t_phase             phase_q;

    t_result            line_results_q [$];

    function automatic logic [COUNT_W-1:0] live_len();
        if (strip_len == '0) return '0;
        if (strip_len < MIN_LEDS) return COUNT_W'(MIN_LEDS);
        if (strip_len > MAX_LEDS) return COUNT_W'(MAX_LEDS);
        return strip_len;
    endfunction

    function automatic logic [7:0] live_mask();
        logic [7:0] m;
        m = '0;
        if (live_len() != '0)
            for (int c = 0; c < CHANNELS && c < 8; c++) m[c] = chan_mask[c];
        return m;
    endfunction

    // 24-bit pixels when white shares the red position
    function automatic logic [4:0] top_bit();
        return (pix_layout[7:6] == pix_layout[5:4]) ? TOP_BIT_24 : TOP_BIT_32;
    endfunction

    function automatic logic [7:0] scaled(logic [7:0] v);
        logic [15:0] p;
        p = 16'(v) * 16'(bright);
        return (bright == '0) ? v : p[15:8];
    endfunction

    function automatic logic [WORD_W-1:0] packed_pixel(t_cmd c);
        logic [WORD_W-1:0] w;
        w = (WORD_W'(scaled(c.red))   << {pix_layout[5:4], 3'b000})
          | (WORD_W'(scaled(c.green)) << {pix_layout[3:2], 3'b000})
          | (WORD_W'(scaled(c.blue))  << {pix_layout[1:0], 3'b000});
        if (top_bit() == TOP_BIT_32)
            w |= WORD_W'(scaled(c.white)) << {pix_layout[7:6], 3'b000};
        return w;
    endfunction

    function automatic void fetch_words();
        logic [COUNT_W-1:0] pos;
        pos = (led_pos < MAX_LEDS) ? led_pos : '0;
        for (int c = 0; c < CHANNELS; c++) out_word[c] = frame_mem[c*MAX_LEDS + pos];
    endfunction

    function automatic logic [7:0] line_state();
        logic [7:0]        lv;
        logic [7:0]        m;
        logic [HIGH_W-1:0] th;
        lv = '0;
        m  = live_mask();
        if (phase_q == PH_SHIFT)
            for (int c = 0; c < CHANNELS && c < 8; c++) begin
                th = out_word[c][bit_pos] ? one_high : zero_high;
                if (m[c] && cyc < th) lv[c] = 1'b1;
            end
        return lv;
    endfunction

    function automatic logic store_pixel(t_cmd c);
        logic [7:0] m;
        m = live_mask();
        if (c.channel >= CHANNELS) return 1'b0;
        if (!m[c.channel]) return 1'b0;
        if (c.led_index >= live_len()) return 1'b0;
        frame_mem[c.channel*MAX_LEDS + c.led_index] = packed_pixel(c);
        return 1'b1;
    endfunction

    function automatic logic begin_show();
        if (phase_q != PH_IDLE) return 1'b0;
        led_pos = '0;
        cyc     = '0;
        if (live_len() == '0) begin
            phase_q = PH_GAP;
            bit_pos = '0;
        end else begin
            fetch_words();
            bit_pos = top_bit();
            phase_q = PH_SHIFT;
        end
        return 1'b1;
    endfunction

    function automatic void advance_cycle();
        logic [CNT_W-1:0] lim;
        case (phase_q)
            PH_SHIFT: begin
                lim = (bit_period == '0) ? CNT_W'(1) : CNT_W'(bit_period);
                cyc = cyc + 1'b1;
                if (cyc >= lim) begin
                    cyc = '0;
                    if (bit_pos == '0) begin
                        led_pos = led_pos + 1'b1;
                        if (led_pos >= live_len()) begin
                            phase_q = PH_GAP;
                        end else begin
                            fetch_words();
                            bit_pos = top_bit();
                        end
                    end else begin
                        bit_pos = bit_pos - 1'b1;
                        if (bit_pos > top_bit()) bit_pos = top_bit();
                    end
                end
            end
            PH_GAP: begin
                lim = (gap_len == '0) ? CNT_W'(1) : gap_len;
                cyc = cyc + 1'b1;
                if (cyc >= lim) begin
                    cyc     = '0;
                    led_pos = '0;
                    bit_pos = '0;
                    phase_q = PH_IDLE;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_result run_cmd(t_cmd c);
        t_result r;
        r.rejected = 1'b0;
        case (c.opcode)
            OP_WRITE: r.rejected = !store_pixel(c);
            OP_SHOW:  r.rejected = !begin_show();
            OP_TICK:  advance_cycle();
            default:  ;
        endcase
        r.line_levels = line_state();
        r.status      = phase_q;
        return r;
    endfunction

    function automatic void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        case (t_cfg_idx'(idx))
            CFG_CHANNEL_MASK: chan_mask  = d[7:0];
            CFG_LED_COUNT:    strip_len  = d[COUNT_W-1:0];
            CFG_PIXEL_TYPE:   pix_layout = d[7:0];
            CFG_BRIGHTNESS:   bright     = d[7:0];
            CFG_ZERO_HIGH:    zero_high  = d[HIGH_W-1:0];
            CFG_ONE_HIGH:     one_high   = d[HIGH_W-1:0];
            CFG_BIT_PERIOD:   bit_period = d[HIGH_W-1:0];
            CFG_RESET_GAP:    gap_len    = d[CNT_W-1:0];
            default:          ;
        endcase
    endfunction

    task automatic note_mismatch(string what, t_result want, t_result got);
        o_mismatches++;
        if (o_mismatches <= REPORT_LIMIT)
            $display("[%0t] %s: expected lines %02h status %0d rejected %0b, got lines %02h status %0d rejected %0b",
                     $time, what, want.line_levels, want.status, want.rejected,
                     got.line_levels, got.status, got.rejected);
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            chan_mask  = '0;
            strip_len  = '0;
            pix_layout = '0;
            bright     = '0;
            zero_high  = HIGH_W'(22);
            one_high   = HIGH_W'(75);
            bit_period = HIGH_W'(97);
            gap_len    = CNT_W'(30000);
            for (int i = 0; i < CHANNELS*MAX_LEDS; i++) frame_mem[i] = '0;
            for (int c = 0; c < CHANNELS; c++) out_word[c] = '0;
            led_pos = '0;
            bit_pos = '0;
            cyc     = '0;
            phase_q = PH_IDLE;
            o_mismatches = 0;
            line_results_q.delete();
        end else begin
            // compare before taking a new command so a same-edge transfer stays ordered
            if (i_done) begin
                if (line_results_q.size() == 0) begin
                    note_mismatch("result with none outstanding", '0, i_result);
                end else begin
                    want = line_results_q.pop_front();
                    if (i_result.line_levels !== want.line_levels ||
                        i_result.status !== want.status ||
                        i_result.rejected !== want.rejected)
                        note_mismatch("result mismatch", want, i_result);
                end
            end
            if (i_cfg_valid && i_cfg_ready) set_register(i_cfg_index, i_cfg_data);
            if (i_start && !i_busy) line_results_q.push_back(run_cmd(i_cmd));
        end
        o_outstanding = line_results_q.size();
    end

endmodule

### verif/tb_top.sv
// Top of the LED strip serializer testbench: clock, reset, command and register stimulus, verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mlss_pkg::*;

    localparam int          CLK_PERIOD   = 20;
    localparam int          RESET_CYCLES = 2;
    localparam int          ITEM_TARGET  = 1800;
    localparam int          MAX_IDLE     = 16;
    localparam int          CHUNK        = 16;
    localparam int          MAX_ROUNDS   = 400;
    localparam int          END_WAIT     = 8;
    localparam int unsigned CYCLE_LIMIT  = 500_000;

    // opcode the block leaves undecoded
    localparam logic [1:0]  OP_UNUSED    = 2'd3;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    t_cmd                  i_cmd       = '0;
    logic                  o_done;
    t_result               o_result;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int                    fails;
    int                    pending;
    logic [1:0]            last_status = PH_IDLE;
    bit                    fast_mode   = 1'b0;
    int                    items_sent  = 0;
    int unsigned           cycle_count = 0;

    multichannel_led_strip_serializer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    mlss_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_cmd         (i_cmd),
        .i_done        (o_done),
        .i_result      (o_result),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (fails),
        .o_outstanding (pending)
    );

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    // Track the waveform phase the block last reported; it tells the stimulus when a show is over.
    always @(posedge i_clk) begin
        if (o_done) last_status <= o_result.status;
    end

    // Hard stop in case the block hangs or drops a result.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Idle gap before the next command: none in fast stretches, else drawn at random, at most MAX_IDLE.
    function automatic int unsigned idle_draw();
        if (fast_mode || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(1, MAX_IDLE);
    endfunction

    // Random command: mostly ticks, with writes, shows and the undecoded opcode mixed in.
    // Channels and LED indexes lean toward the live range but reach every bit.
    function automatic t_cmd random_item();
        t_cmd c;
        c.channel   = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(8, 31))
                                                  : 5'($urandom_range(0, 7));
        c.led_index = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1023))
                                                  : 10'($urandom_range(0, 7));
        c.red       = 8'($urandom_range(0, 255));
        c.green     = 8'($urandom_range(0, 255));
        c.blue      = 8'($urandom_range(0, 255));
        c.white     = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 15))
            0, 1, 2: c.opcode = OP_WRITE;
            3:       c.opcode = OP_SHOW;
            4:       c.opcode = OP_UNUSED;
            default: c.opcode = OP_TICK;
        endcase
        return c;
    endfunction

    // Random payload under a fixed opcode.
    function automatic t_cmd item_of(logic [1:0] op);
        t_cmd c;
        c        = random_item();
        c.opcode = op;
        return c;
    endfunction

    function automatic t_cmd pixel_write(logic [4:0] ch, logic [9:0] idx,
                                         logic [7:0] r, logic [7:0] g,
                                         logic [7:0] b, logic [7:0] w);
        t_cmd c;
        c.opcode    = OP_WRITE;
        c.channel   = ch;
        c.led_index = idx;
        c.red       = r;
        c.green     = g;
        c.blue      = b;
        c.white     = w;
        return c;
    endfunction

    // Register values that keep a frame to a few hundred ticks.
    function automatic logic [CFG_DATA_W-1:0] small_value(t_cfg_idx idx);
        case (idx)
            CFG_CHANNEL_MASK: return CFG_DATA_W'($urandom_range(0, 255));
            CFG_LED_COUNT:    return CFG_DATA_W'($urandom_range(0, 6));
            CFG_PIXEL_TYPE:   return CFG_DATA_W'($urandom_range(0, 255));
            CFG_BRIGHTNESS:   return ($urandom_range(0, 2) == 0) ? '0
                                     : CFG_DATA_W'($urandom_range(1, 255));
            CFG_BIT_PERIOD:   return CFG_DATA_W'($urandom_range(0, 4));
            CFG_RESET_GAP:    return CFG_DATA_W'($urandom_range(0, 12));
            default:          return CFG_DATA_W'($urandom_range(0, 6));
        endcase
    endfunction

    // Issue one command and return at the edge that transfers it.
    task automatic send_cmd(t_cmd c);
        int unsigned gap;
        gap = idle_draw();
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        // hold start high straight into the next command when no gap is drawn
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        if (c.opcode != OP_UNUSED) items_sent++;
    endtask

    // Drop start and wait until every result has come back.
    task automatic drain();
        @(negedge i_clk);
        start       <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Register write; only once no command is in flight.
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Feed mixed commands in chunks until the block reports idle or MAX_ROUNDS chunks have run;
    // between chunks, sometimes retune one register so changes land in the middle of a show.
    task automatic run_until_idle();
        int unsigned rounds;
        t_cfg_idx    idx;
        rounds = 0;
        do begin
            repeat (CHUNK) send_cmd(random_item());
            drain();
            rounds++;
            if ($urandom_range(0, 5) == 0) begin
                idx = t_cfg_idx'($urandom_range(0, 7));
                write_reg(idx, small_value(idx));
            end
        end while (last_status != PH_IDLE && rounds < MAX_ROUNDS);
    endtask

    // One frame: fresh registers, some pixels, a show, then the waveform to its end.
    task automatic run_frame();
        int unsigned fills;
        fast_mode = ($urandom_range(0, 2) == 0);
        for (int r = 0; r < 8; r++) write_reg(t_cfg_idx'(r), small_value(t_cfg_idx'(r)));
        fills = $urandom_range(4, 16);
        repeat (fills) send_cmd(item_of(OP_WRITE));
        send_cmd(item_of(OP_SHOW));
        run_until_idle();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Widest registers: LED count past the store clamps, 32-bit pixels, full brightness.
        write_reg(CFG_CHANNEL_MASK, 20'hFF);
        write_reg(CFG_LED_COUNT, 20'h7FF);
        write_reg(CFG_PIXEL_TYPE, 20'hE4);
        write_reg(CFG_BRIGHTNESS, 20'hFF);
        send_cmd(pixel_write(5'd0, 10'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_cmd(pixel_write(5'd7, 10'd1023, 8'h80, 8'h01, 8'h00, 8'hFF));
        // channels past the last strip are refused
        send_cmd(pixel_write(5'd8, 10'd0, 8'h11, 8'h22, 8'h33, 8'h44));
        send_cmd(pixel_write(5'd31, 10'd1023, 8'hFF, 8'h00, 8'hFF, 8'h00));
        send_cmd(item_of(OP_UNUSED));

        write_reg(CFG_LED_COUNT, 20'd1024);
        send_cmd(pixel_write(5'd3, 10'd1023, 8'h5A, 8'hA5, 8'hC3, 8'h3C));

        // counts of one and two act as three: index two fits, three does not
        write_reg(CFG_LED_COUNT, 20'd1);
        send_cmd(pixel_write(5'd4, 10'd2, 8'h01, 8'h02, 8'h04, 8'h08));
        send_cmd(pixel_write(5'd4, 10'd3, 8'h10, 8'h20, 8'h40, 8'h80));

        // disabled channel, then no scaling
        write_reg(CFG_CHANNEL_MASK, 20'h7F);
        write_reg(CFG_BRIGHTNESS, '0);
        send_cmd(pixel_write(5'd7, 10'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_cmd(pixel_write(5'd6, 10'd1, 8'hFE, 8'h7F, 8'h01, 8'h80));

        // every byte at position zero: 24-bit, colors OR together
        write_reg(CFG_PIXEL_TYPE, 20'h00);
        send_cmd(pixel_write(5'd2, 10'd0, 8'h0F, 8'hF0, 8'h3C, 8'hAA));
        // every byte at position three: stored but never shifted out
        write_reg(CFG_PIXEL_TYPE, 20'hFF);
        send_cmd(pixel_write(5'd1, 10'd1, 8'h81, 8'h42, 8'h24, 8'h18));

        // Zero LEDs: writes refused, show goes straight to the reset gap.
        write_reg(CFG_LED_COUNT, '0);
        send_cmd(pixel_write(5'd0, 10'd0, 8'h12, 8'h34, 8'h56, 8'h78));
        send_cmd(item_of(OP_SHOW));
        send_cmd(item_of(OP_TICK));
        send_cmd(item_of(OP_SHOW));
        write_reg(CFG_RESET_GAP, 20'hFFFFF);
        send_cmd(item_of(OP_TICK));
        // a zero gap is taken as a value of one, so this tick ends the gap at once
        write_reg(CFG_RESET_GAP, '0);
        send_cmd(item_of(OP_TICK));

        // Longest bit timing, then a zero period and swapped high times mid-bit.
        write_reg(CFG_LED_COUNT, 20'd3);
        write_reg(CFG_PIXEL_TYPE, 20'hE4);
        write_reg(CFG_BIT_PERIOD, 20'hFFF);
        write_reg(CFG_ZERO_HIGH, 20'hFFF);
        write_reg(CFG_ONE_HIGH, '0);
        send_cmd(item_of(OP_SHOW));
        send_cmd(item_of(OP_TICK));
        send_cmd(item_of(OP_TICK));
        write_reg(CFG_BIT_PERIOD, '0);
        send_cmd(item_of(OP_TICK));
        send_cmd(item_of(OP_TICK));
        write_reg(CFG_ZERO_HIGH, '0);
        write_reg(CFG_ONE_HIGH, 20'hFFF);
        send_cmd(item_of(OP_TICK));
        write_reg(CFG_BIT_PERIOD, 20'd1);
        write_reg(CFG_RESET_GAP, 20'd2);
        run_until_idle();

        // Random frames until enough commands have gone in.
        while (items_sent < ITEM_TARGET) run_frame();

        drain();
        repeat (END_WAIT) @(posedge i_clk);
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/mlss_pkg.sv
hw/rtl/mlss_store.sv
hw/rtl/mlss_pack.sv
hw/rtl/mlss_line.sv
hw/rtl/multichannel_led_strip_serializer.sv
verif/mlss_checker.sv
verif/tb_top.sv
